// ----- design/assert_macros.svh -----
// Assertion macros shared by the ring filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define CHR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, checked on every clk edge outside reset.
`define CHR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// ----- design/chr_pkg.sv -----
// Shared widths, constants and register codes of the ring filter.
package chr_pkg;

  // Field widths of the channels
  localparam int PIX_W  = 16;
  localparam int RESP_W = 29;
  localparam int CFG_W  = 9;
  localparam int DIM_REG_W = 9;
  localparam int RAD_W  = 8;

  // Datapath widths of the gradient magnitude path
  localparam int GX_W   = 21;
  localparam int SQ_W   = 42;
  localparam int ROOT_W = 21;
  localparam int SRC_W  = ROOT_W;
  localparam int SREM_W = 25;

  // Smallest accepted frame dimension
  localparam int MIN_DIM = 17;
  // Half a pixel in radius units
  localparam int HALF_PIX = 8;

  // Scharr taps
  localparam logic signed [GX_W-1:0] SCHARR_SIDE = 3;
  localparam logic signed [GX_W-1:0] SCHARR_MID  = 10;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_RADIUS       = 2'd2,
    CFG_USE_GRADIENT = 2'd3
  } cfg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [RESP_W-1:0] resp_t;

endpackage

// ----- design/chr_if.sv -----
// Valid/ready channel interfaces for the input and result beats.
interface chr_in_if;
  logic                valid;
  logic                ready;
  logic                kind;
  chr_pkg::pix_t       pixel_value;

  modport source (output valid, kind, pixel_value, input ready);
  modport sink   (input valid, kind, pixel_value, output ready);
endinterface

interface chr_out_if;
  logic                valid;
  logic                ready;
  chr_pkg::resp_t      response;
  logic                last_of_frame;
  logic                not_ready;

  modport source (output valid, response, last_of_frame, not_ready, input ready);
  modport sink   (input valid, response, last_of_frame, not_ready, output ready);
endinterface

// ----- design/chr_store.sv -----
// Frame store: one write port, one registered read port.
module chr_store #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rd_data_r
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write on load beats
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read every cycle, data registered and available in the next cycle
  always_ff @(posedge clk) begin
    rd_data_r <= mem[raddr];
  end

endmodule

// ----- design/chr_csub.sv -----
// Shared compare-subtract unit for the square root, rounding and divider steps.
module chr_csub #(
  parameter int W = 25
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         ge
);

  logic [W:0] full;

  // Borrow clear means a >= b
  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[W-1:0];
  assign ge   = ~full[W];

endmodule

// ----- design/circular_hough_ring_filter.sv -----
// Ring filter top: loads a frame into the store, then answers each readout
// request with the mean over a ring of offsets around the next output pixel
// of the source image or, with the gradient on, of its Scharr gradient
// magnitude. A request runs through a sequencer around one shared
// compare-subtract unit and the single read port of the frame store: it scans
// each of the (2*MAX_RADIUS+1)^2 offsets, then per ring sample reads one raw
// pixel or, with the gradient on, makes nine store reads and a 21-step square
// root, then runs a bit-serial rounding divide over NUM_W bits (NUM_W is 40
// at the default sizes). An early request, before the frame is loaded,
// skips the scan and answers with a zero not_ready result. in_chan.ready is
// low while a request is being worked on.
`include "assert_macros.svh"

module circular_hough_ring_filter #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  chr_in_if.sink                        in_chan,
  chr_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [chr_pkg::CFG_W-1:0]     cfg_data
);

  // ---------------------------------------------------------------- sizes
  localparam int DIM_MAX = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int LPOS_W  = $clog2(DEPTH + 1);
  localparam int TOT_W   = 2 * chr_pkg::DIM_REG_W;
  localparam int CW      = (LPOS_W > TOT_W) ? LPOS_W : TOT_W;
  localparam int DIM_W   = $clog2(DIM_MAX);
  localparam int DW      = (DIM_W > chr_pkg::DIM_REG_W) ? DIM_W : chr_pkg::DIM_REG_W;
  localparam int CRD_W   = $clog2(2 * DIM_MAX + MAX_RADIUS + 2) + 1;
  localparam int OFF_W   = $clog2(MAX_RADIUS + 1) + 1;
  localparam int D2S_W   = 2 * OFF_W + 9;
  localparam int HI_W    = 2 * chr_pkg::RAD_W + 2;
  localparam int LO_W    = 2 * chr_pkg::RAD_W;
  localparam int CMP_W   = (D2S_W > HI_W) ? D2S_W : HI_W;
  localparam int CNT_W   = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
  localparam int SUM_W   = chr_pkg::SRC_W + CNT_W;
  localparam int NUM_W   = SUM_W + 9;
  localparam int SW      = (chr_pkg::SREM_W > CNT_W + 1) ? chr_pkg::SREM_W : CNT_W + 1;
  localparam int STEP_W  = $clog2(NUM_W + 1);
  localparam int RAD_MAX = MAX_RADIUS * 16;
  localparam int RST_WID = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int RST_HEI = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
  localparam int RST_RAD = (RAD_MAX < 80) ? RAD_MAX : 80;

  localparam logic signed [OFF_W-1:0] OFF_MAX = OFF_W'(MAX_RADIUS);
  localparam logic signed [OFF_W-1:0] OFF_MIN = -OFF_MAX;
  localparam logic signed [OFF_W-1:0] ONE_O   = 1;
  localparam logic signed [CRD_W-1:0] ONE_C   = 1;

  typedef logic [chr_pkg::DIM_REG_W-1:0] dim_t;
  typedef logic signed [CRD_W-1:0]       crd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_FOLD, S_ADDR, S_READ, S_TAP, S_GRAD, S_SQ1, S_SQ2,
    S_SQRT, S_RND, S_ACC, S_DIVI, S_DIV, S_EMIT
  } seq_state_t;

  // -------------------------------------------------------------- registers
  dim_t                    wid_r, hei_r;
  logic [chr_pkg::RAD_W-1:0] rad_cfg_r;
  logic                    grad_r;
  logic [LPOS_W-1:0]       load_pos_r;
  logic                    frame_done_r;
  logic [DIM_W-1:0]        rd_x_r, rd_y_r;

  seq_state_t              state_r;
  logic signed [OFF_W-1:0] dx_r, dy_r;
  logic                    scan_done_r;
  logic [HI_W-1:0]         hi2_r;
  logic [LO_W-1:0]         lo2_r;
  logic                    r_small_r;
  crd_t                    xi_r, yi_r, cx_r, cy_r;
  logic                    center_r;
  logic [1:0]              kx_r, ky_r;
  logic [3:0]              tap_k_r;
  chr_pkg::pix_t           tap_r [9];
  logic [ADDR_W-1:0]       addr_r;
  logic signed [chr_pkg::GX_W-1:0] gx_r, gy_r;
  logic [chr_pkg::SQ_W-1:0]   sq_r, rad_r;
  logic [chr_pkg::ROOT_W-1:0] root_r;
  logic [SW-1:0]           rem_r;
  logic [STEP_W-1:0]       step_r;
  logic [chr_pkg::SRC_W-1:0] src_r;
  logic [SUM_W-1:0]        sum_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [NUM_W-1:0]        q_r;
  chr_pkg::resp_t          resp_r;
  logic                    nr_r;

  logic                    out_valid_r;
  chr_pkg::resp_t          out_resp_r;
  logic                    out_last_r;
  logic                    out_nr_r;

  // ------------------------------------------------------------ handshakes
  logic in_acc, out_free, rd_adv;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign rd_adv   = (state_r == S_EMIT) && out_free && !nr_r;

  assign out_chan.valid         = out_valid_r;
  assign out_chan.response      = out_resp_r;
  assign out_chan.last_of_frame = out_last_r;
  assign out_chan.not_ready     = out_nr_r;

  // ----------------------------------------------------------- frame store
  logic [TOT_W-1:0]  total;
  logic [LPOS_W-1:0] lp_base, lp_inc;
  logic              store_we;
  chr_pkg::pix_t     rd_data_r;

  assign total    = TOT_W'(wid_r) * TOT_W'(hei_r);
  assign lp_base  = frame_done_r ? '0 : load_pos_r;
  assign lp_inc   = lp_base + LPOS_W'(1);
  assign store_we = in_acc && !in_chan.kind && (CW'(lp_base) < CW'(total));

  chr_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (chr_pkg::PIX_W)
  ) u_store (
    .clk       (clk),
    .we        (store_we),
    .waddr     (lp_base[ADDR_W-1:0]),
    .wdata     (in_chan.pixel_value),
    .raddr     (addr_r),
    .rd_data_r (rd_data_r)
  );

  // --------------------------------------------------- config and position
  logic [chr_pkg::DIM_REG_W-1:0] cfg_dim;
  dim_t                          wid_sat, hei_sat;
  logic [chr_pkg::RAD_W-1:0]     rad_sat;
  logic                          rd_x_last, rd_y_last;

  assign cfg_dim = cfg_data[chr_pkg::DIM_REG_W-1:0];

  // Saturate the written values into their ranges
  always_comb begin
    if (int'(cfg_dim) < chr_pkg::MIN_DIM) begin
      wid_sat = dim_t'(chr_pkg::MIN_DIM);
      hei_sat = dim_t'(chr_pkg::MIN_DIM);
    end else begin
      wid_sat = (int'(cfg_dim) > MAX_WIDTH)  ? dim_t'(MAX_WIDTH)  : cfg_dim;
      hei_sat = (int'(cfg_dim) > MAX_HEIGHT) ? dim_t'(MAX_HEIGHT) : cfg_dim;
    end
    rad_sat = (int'(cfg_data[chr_pkg::RAD_W-1:0]) > RAD_MAX) ?
              chr_pkg::RAD_W'(RAD_MAX) : cfg_data[chr_pkg::RAD_W-1:0];
  end

  assign rd_x_last = (DW'(rd_x_r) == DW'(wid_r) - DW'(1));
  assign rd_y_last = (DW'(rd_y_r) == DW'(hei_r) - DW'(1));

  // Hold configuration, load count and readout position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wid_r        <= dim_t'(RST_WID);
      hei_r        <= dim_t'(RST_HEI);
      rad_cfg_r    <= chr_pkg::RAD_W'(RST_RAD);
      grad_r       <= 1'b1;
      load_pos_r   <= '0;
      frame_done_r <= 1'b0;
      rd_x_r       <= '0;
      rd_y_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        chr_pkg::CFG_IMAGE_WIDTH: begin
          wid_r        <= wid_sat;
          load_pos_r   <= '0;
          frame_done_r <= 1'b0;
          rd_x_r       <= '0;
          rd_y_r       <= '0;
        end
        chr_pkg::CFG_IMAGE_HEIGHT: begin
          hei_r        <= hei_sat;
          load_pos_r   <= '0;
          frame_done_r <= 1'b0;
          rd_x_r       <= '0;
          rd_y_r       <= '0;
        end
        chr_pkg::CFG_RADIUS:       rad_cfg_r <= rad_sat;
        chr_pkg::CFG_USE_GRADIENT: grad_r    <= cfg_data[0];
        default: ;
      endcase
    end else if (in_acc && !in_chan.kind) begin
      // Load beat, a load after a full frame opens a new one
      load_pos_r   <= lp_inc;
      frame_done_r <= (CW'(lp_inc) >= CW'(total));
      if (frame_done_r) begin
        rd_x_r <= '0;
        rd_y_r <= '0;
      end
    end else if (rd_adv) begin
      // Advance readout in raster order, wrap after the frame
      if (rd_x_last) begin
        rd_x_r <= '0;
        rd_y_r <= rd_y_last ? '0 : rd_y_r + DIM_W'(1);
      end else begin
        rd_x_r <= rd_x_r + DIM_W'(1);
      end
    end
  end

  // ------------------------------------------------------------ ring test
  logic [2*OFF_W-1:0] dx_sq, dy_sq;
  logic [CMP_W-1:0]   d2s;
  logic               in_ring, last_off;

  assign dx_sq = (2*OFF_W)'(dx_r) * (2*OFF_W)'(dx_r);
  assign dy_sq = (2*OFF_W)'(dy_r) * (2*OFF_W)'(dy_r);
  assign d2s   = CMP_W'({({1'b0, dx_sq} + {1'b0, dy_sq}), 8'b0});
  assign in_ring = (d2s < CMP_W'(hi2_r)) && (r_small_r || (d2s > CMP_W'(lo2_r)));
  assign last_off = (dx_r == OFF_MAX) && (dy_r == OFF_MAX);

  // --------------------------------------------------------- edge mirror
  function automatic crd_t fold_step(input crd_t v, input dim_t n);
    crd_t nn, n2;
    nn = $signed(CRD_W'(n));
    n2 = nn + nn;
    if (v < 0) begin
      fold_step = v + n2;
    end else if (v >= n2) begin
      fold_step = v - n2;
    end else if (v >= nn) begin
      fold_step = n2 - ONE_C - v;
    end else begin
      fold_step = v;
    end
  endfunction

  logic x_ok, y_ok;
  assign x_ok = (xi_r >= 0) && (xi_r < $signed(CRD_W'(wid_r)));
  assign y_ok = (yi_r >= 0) && (yi_r < $signed(CRD_W'(hei_r)));

  // ------------------------------------------------------- address and taps
  logic [DIM_W+chr_pkg::DIM_REG_W:0] addr_full;
  logic [1:0] kx_n, ky_n;
  crd_t       nb_x, nb_y;

  assign addr_full = (DIM_W+chr_pkg::DIM_REG_W+1)'(yi_r[DIM_W-1:0]) *
                     (DIM_W+chr_pkg::DIM_REG_W+1)'(wid_r) +
                     (DIM_W+chr_pkg::DIM_REG_W+1)'(xi_r[DIM_W-1:0]);

  // Next 3x3 neighbor in raster order
  always_comb begin
    if (kx_r == 2'd2) begin
      kx_n = 2'd0;
      ky_n = ky_r + 2'd1;
    end else begin
      kx_n = kx_r + 2'd1;
      ky_n = ky_r;
    end
    nb_x = cx_r + $signed({{(CRD_W-2){1'b0}}, kx_n}) - ONE_C;
    nb_y = cy_r + $signed({{(CRD_W-2){1'b0}}, ky_n}) - ONE_C;
  end

  // Scharr responses from the nine taps
  logic signed [chr_pkg::GX_W-1:0] gx_c, gy_c;
  logic signed [chr_pkg::GX_W-1:0] te [9];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      te[i] = $signed({{(chr_pkg::GX_W-chr_pkg::PIX_W){1'b0}}, tap_r[i]});
    end
    gx_c = chr_pkg::SCHARR_SIDE * (te[2] - te[0])
         + chr_pkg::SCHARR_MID  * (te[5] - te[3])
         + chr_pkg::SCHARR_SIDE * (te[8] - te[6]);
    gy_c = chr_pkg::SCHARR_SIDE * (te[6] - te[0])
         + chr_pkg::SCHARR_MID  * (te[7] - te[1])
         + chr_pkg::SCHARR_SIDE * (te[8] - te[2]);
  end

  logic signed [chr_pkg::SQ_W-1:0] gxe, gye;
  assign gxe = chr_pkg::SQ_W'(gx_r);
  assign gye = chr_pkg::SQ_W'(gy_r);

  // ------------------------------------------------ shared compare-subtract
  logic [SW-1:0] su_a, su_b, su_diff;
  logic          su_ge;

  always_comb begin
    su_a = '0;
    su_b = '0;
    case (state_r)
      S_SQRT: begin
        su_a = {rem_r[SW-3:0], rad_r[chr_pkg::SQ_W-1 -: 2]};
        su_b = SW'({root_r, 2'b01});
      end
      S_RND: begin
        su_a = SW'(root_r);
        su_b = rem_r;
      end
      S_DIV: begin
        su_a = {rem_r[SW-2:0], q_r[NUM_W-1]};
        su_b = SW'(cnt_r);
      end
      default: ;
    endcase
  end

  chr_csub #(.W(SW)) u_csub (
    .a    (su_a),
    .b    (su_b),
    .diff (su_diff),
    .ge   (su_ge)
  );

  logic [NUM_W-1:0] q_shift;
  logic [NUM_W-1:0] num;
  logic [chr_pkg::RAD_W:0]   rp8;
  logic [chr_pkg::RAD_W-1:0] rm8;

  assign q_shift = {q_r[NUM_W-2:0], su_ge};
  assign num     = NUM_W'({sum_r, 8'b0}) + NUM_W'(cnt_r >> 1);
  assign rp8     = {1'b0, rad_cfg_r} + (chr_pkg::RAD_W+1)'(chr_pkg::HALF_PIX);
  assign rm8     = rad_cfg_r - chr_pkg::RAD_W'(chr_pkg::HALF_PIX);

  // ------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the result once taken, load a new one from the emit step
      if ((state_r == S_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
        out_resp_r  <= resp_r;
        out_nr_r    <= nr_r;
        out_last_r  <= !nr_r && rd_x_last && rd_y_last;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_chan.kind) begin
            if (!frame_done_r) begin
              resp_r  <= '0;
              nr_r    <= 1'b1;
              state_r <= S_EMIT;
            end else begin
              nr_r        <= 1'b0;
              dx_r        <= OFF_MIN;
              dy_r        <= OFF_MIN;
              scan_done_r <= 1'b0;
              sum_r       <= '0;
              cnt_r       <= '0;
              hi2_r       <= HI_W'(rp8) * HI_W'(rp8);
              lo2_r       <= LO_W'(rm8) * LO_W'(rm8);
              r_small_r   <= (int'(rad_cfg_r) < chr_pkg::HALF_PIX);
              state_r     <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_done_r) begin
            state_r <= S_DIVI;
          end else begin
            // Advance the offset, start a sample when it lies on the ring
            if (dx_r == OFF_MAX) begin
              dx_r <= OFF_MIN;
              dy_r <= dy_r + ONE_O;
            end else begin
              dx_r <= dx_r + ONE_O;
            end
            scan_done_r <= last_off;
            if (in_ring) begin
              xi_r     <= $signed({{(CRD_W-DIM_W){1'b0}}, rd_x_r}) + CRD_W'(dx_r);
              yi_r     <= $signed({{(CRD_W-DIM_W){1'b0}}, rd_y_r}) + CRD_W'(dy_r);
              center_r <= 1'b1;
              state_r  <= S_FOLD;
            end
          end
        end
        S_FOLD: begin
          if (x_ok && y_ok) begin
            if (center_r && grad_r) begin
              cx_r     <= xi_r;
              cy_r     <= yi_r;
              xi_r     <= xi_r - ONE_C;
              yi_r     <= yi_r - ONE_C;
              kx_r     <= 2'd0;
              ky_r     <= 2'd0;
              tap_k_r  <= 4'd0;
              center_r <= 1'b0;
            end else begin
              state_r <= S_ADDR;
            end
          end else begin
            xi_r <= fold_step(xi_r, wid_r);
            yi_r <= fold_step(yi_r, hei_r);
          end
        end
        S_ADDR: begin
          addr_r  <= ADDR_W'(addr_full);
          state_r <= S_READ;
        end
        S_READ: begin
          state_r <= S_TAP;
        end
        S_TAP: begin
          if (!grad_r) begin
            src_r   <= chr_pkg::SRC_W'(rd_data_r);
            state_r <= S_ACC;
          end else begin
            tap_r[tap_k_r] <= rd_data_r;
            if (tap_k_r == 4'd8) begin
              state_r <= S_GRAD;
            end else begin
              tap_k_r <= tap_k_r + 4'd1;
              kx_r    <= kx_n;
              ky_r    <= ky_n;
              xi_r    <= nb_x;
              yi_r    <= nb_y;
              state_r <= S_FOLD;
            end
          end
        end
        S_GRAD: begin
          gx_r    <= gx_c;
          gy_r    <= gy_c;
          state_r <= S_SQ1;
        end
        S_SQ1: begin
          sq_r    <= gxe * gxe;
          state_r <= S_SQ2;
        end
        S_SQ2: begin
          rad_r   <= sq_r + gye * gye;
          root_r  <= '0;
          rem_r   <= '0;
          step_r  <= STEP_W'(chr_pkg::ROOT_W);
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          // One root bit per step
          rem_r  <= su_ge ? su_diff : su_a;
          root_r <= {root_r[chr_pkg::ROOT_W-2:0], su_ge};
          rad_r  <= rad_r << 2;
          step_r <= step_r - STEP_W'(1);
          if (step_r == STEP_W'(1)) begin
            state_r <= S_RND;
          end
        end
        S_RND: begin
          // Round up when the remainder exceeds the root
          src_r   <= chr_pkg::SRC_W'(root_r) + chr_pkg::SRC_W'(!su_ge);
          state_r <= S_ACC;
        end
        S_ACC: begin
          sum_r   <= sum_r + SUM_W'(src_r);
          cnt_r   <= cnt_r + CNT_W'(1);
          state_r <= S_SCAN;
        end
        S_DIVI: begin
          if (cnt_r == '0) begin
            resp_r  <= '0;
            state_r <= S_EMIT;
          end else begin
            q_r     <= num;
            rem_r   <= '0;
            step_r  <= STEP_W'(NUM_W);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          // One quotient bit per step
          rem_r  <= su_ge ? su_diff : su_a;
          q_r    <= q_shift;
          step_r <= step_r - STEP_W'(1);
          if (step_r == STEP_W'(1)) begin
            resp_r  <= q_shift[chr_pkg::RESP_W-1:0];
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // ------------------------------------------------------------ assertions
  `CHR_ASSERT_IMP(a_nr_zero, out_valid_r && out_nr_r, (out_resp_r == '0) && !out_last_r)
  `CHR_ASSERT_IMP(a_full_count, frame_done_r, CW'(load_pos_r) == CW'(total))
  `CHR_ASSERT_NXT(a_early_req, in_acc && in_chan.kind && !frame_done_r, state_r == S_EMIT)
  `CHR_ASSERT_IMP(a_rd_inside, frame_done_r,
                  (DW'(rd_x_r) < DW'(wid_r)) && (DW'(rd_y_r) < DW'(hei_r)))

endmodule
